FILE: sv/slr_pkg.sv
package slr_pkg;

   localparam logic [18:0] BAUD_MIN       = 19'd2400;
   localparam logic [31:0] BAUD_MAX       = 32'd460800;
   localparam logic [8:0]  FLAGS_REQUIRED = 9'h10B;
   localparam logic [8:0]  FLAGS_ALL_INFO = 9'h1F8;

   localparam logic [7:0] HDR_MASK   = 8'hC0;
   localparam logic [7:0] HDR_SYS    = 8'h00;
   localparam logic [7:0] HDR_CMD    = 8'h40;
   localparam logic [7:0] HDR_INFO   = 8'h80;
   localparam logic [7:0] TYPE_HDR   = 8'h40;
   localparam logic [7:0] BYTE_FF    = 8'hFF;
   localparam logic [2:0] SYS_SYNC   = 3'd0;
   localparam logic [2:0] SYS_ACK    = 3'd4;
   localparam logic [2:0] CMD_MODES  = 3'd1;
   localparam logic [2:0] CMD_SPEED  = 3'd2;
   localparam logic [7:0] INFO_NAME  = 8'h00;
   localparam logic [7:0] INFO_UNITS = 8'h04;
   localparam logic [7:0] INFO_FMT   = 8'h80;
   localparam logic [7:0] CHAR_LO    = 8'h41;
   localparam logic [7:0] CHAR_HI    = 8'h7A;

   localparam int COUNT_W = 6;
   localparam logic [COUNT_W-1:0] RES_MAX = 6'd32;

   localparam logic [3:0] KIND_SYNCED = 4'd0;
   localparam logic [3:0] KIND_MODES  = 4'd1;
   localparam logic [3:0] KIND_SPEED  = 4'd2;
   localparam logic [3:0] KIND_NAME   = 4'd3;
   localparam logic [3:0] KIND_UNITS  = 4'd7;
   localparam logic [3:0] KIND_FORMAT = 4'd8;
   localparam logic [3:0] KIND_ACK    = 4'd9;
   localparam logic [3:0] KIND_DATA   = 4'd10;
   localparam logic [3:0] KIND_LOST   = 4'd11;
   localparam logic [3:0] KIND_NACK   = 4'd12;

   localparam logic [1:0] REG_MAX_ERRORS  = 2'd0;
   localparam logic [1:0] REG_HIGHEST_TYP = 2'd1;

   typedef enum logic [3:0] {
      JOB_SYNCED, JOB_MODES, JOB_SPEED, JOB_NAME, JOB_RANGE, JOB_UNITS,
      JOB_UNITS_EMPTY, JOB_FORMAT, JOB_ACK, JOB_DATA, JOB_NACK, JOB_LOST
   } job_type;

   typedef struct packed {
      logic       capture;
      logic       dispatch;
      logic       apply_frame;
      logic       put;
      job_type    job;
      logic [4:0] idx;
      logic       last;
   } dp_cmd_type;

   typedef struct packed {
      logic               slot_free;
      logic               disp_emit;
      job_type            disp_job;
      logic               disp_lost;
      logic               disp_frame;
      logic               frm_lose;
      logic               frm_emit;
      job_type            frm_job;
      logic [COUNT_W-1:0] frm_count;
      logic               frm_check_lose;
   } dp_status_type;

   function automatic logic [7:0] frame_len(input logic [7:0] h);
      logic [7:0] s;
      s = 8'd0;
      if ((h & HDR_MASK) == HDR_SYS) begin
         s = 8'd1;
      end else begin
         s = (8'd1 << h[5:3]) + 8'd2;
         if ((h & HDR_MASK) == HDR_INFO) begin
            s = s + 8'd1;
         end
      end
      return s;
   endfunction

endpackage

FILE: sv/slr_req_if.sv
interface slr_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink (input valid, input func, input rx_byte, output ready);
endinterface

FILE: sv/slr_rsp_if.sv
interface slr_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic [2:0]  mode;
   logic [4:0]  index;
   logic [31:0] value;
   logic        last;

   modport source (output valid, output kind, output mode, output index, output value,
                   output last, input ready);
   modport sink (input valid, input kind, input mode, input index, input value,
                 input last, output ready);
endinterface

FILE: sv/sensor_uart_link_receiver_top.sv
// sensor serial link receiver
// req_chan carries one beat per received byte (func 0, rx_byte) or per
// keep-alive period (func 1). rsp_chan returns the results that beat causes,
// one result per beat, the final one flagged by last.
// a beat is taken only while the controller is idle; each beat passes the
// dispatch state, then the frame state when it completes a frame, then for
// each result a fetch (memory read of the frame store) and a put (output
// register load). the output register holds the last result while the next
// beat is taken; when the receiver stalls rsp_chan the sequencer waits before
// each further result, and req_chan stays not ready until the last result
// of the run is loaded into the output register.
// synchronous reset returns the link to hunting for sync at 2400 baud and
// loads max_data_errors 6 and highest_sensor_type 101; no clearing pass.
// csr port: max_data_errors at byte 0, highest_sensor_type at byte 4,
// pready always high, write on the access cycle.
module sensor_uart_link_receiver_top #(
   parameter int FRAME_DEPTH = 64,
   parameter int MODE_LIMIT  = 7,
   parameter int NAME_LEN    = 11,
   parameter int UNIT_LEN    = 4
) (
   input  logic        clock,
   input  logic        reset,
   slr_req_if.sink     req_chan,
   slr_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import slr_pkg::*;

   logic [3:0]    max_errors_ff;
   logic [7:0]    highest_type_ff;
   logic [1:0]    reg_sel;
   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_pready = 1'b1;
   assign reg_sel    = {1'b0, csr_paddr[2]};

   always_ff @(posedge clock) begin
      if (reset) begin
         max_errors_ff   <= 4'd6;
         highest_type_ff <= 8'd101;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_sel)
            REG_MAX_ERRORS:  max_errors_ff   <= csr_pwdata[3:0];
            REG_HIGHEST_TYP: highest_type_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_MAX_ERRORS:  csr_prdata = {28'd0, max_errors_ff};
         REG_HIGHEST_TYP: csr_prdata = {24'd0, highest_type_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   slr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   slr_datapath #(
      .FRAME_DEPTH (FRAME_DEPTH),
      .MODE_LIMIT  (MODE_LIMIT),
      .NAME_LEN    (NAME_LEN),
      .UNIT_LEN    (UNIT_LEN)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .func_in      (req_chan.func),
      .byte_in      (req_chan.rx_byte),
      .max_errors   (max_errors_ff),
      .highest_type (highest_type_ff),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_kind     (rsp_chan.kind),
      .rsp_mode     (rsp_chan.mode),
      .rsp_index    (rsp_chan.index),
      .rsp_value    (rsp_chan.value),
      .rsp_last     (rsp_chan.last)
   );
endmodule

FILE: sv/slr_ctrl.sv
module slr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  slr_pkg::dp_status_type status,
   output slr_pkg::dp_cmd_type    cmd
);
   import slr_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_DISPATCH, S_FRAME, S_FETCH, S_PUT} state_type;

   state_type          state_ff;
   job_type            job_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [4:0]         idx_ff;
   logic               trail_ff;
   logic               at_end;

   assign req_ready = (state_ff == S_IDLE);
   assign at_end    = ({1'b0, idx_ff} == count_ff - 6'd1);

   always_comb begin
      cmd.capture     = (state_ff == S_IDLE) && req_valid;
      cmd.dispatch    = (state_ff == S_DISPATCH);
      cmd.apply_frame = (state_ff == S_FRAME);
      cmd.put         = (state_ff == S_PUT) && status.slot_free;
      cmd.job         = job_ff;
      cmd.idx         = idx_ff;
      cmd.last        = at_end && !trail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         job_ff   <= JOB_LOST;
         count_ff <= '0;
         idx_ff   <= '0;
         trail_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_DISPATCH;
            end
            S_DISPATCH: begin
               idx_ff   <= '0;
               count_ff <= 6'd1;
               trail_ff <= 1'b0;
               if (status.disp_emit) begin
                  job_ff   <= status.disp_job;
                  state_ff <= S_FETCH;
               end else if (status.disp_lost) begin
                  job_ff   <= JOB_LOST;
                  state_ff <= S_FETCH;
               end else if (status.disp_frame) begin
                  state_ff <= S_FRAME;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_FRAME: begin
               idx_ff <= '0;
               if (status.frm_lose) begin
                  job_ff   <= JOB_LOST;
                  count_ff <= 6'd1;
                  trail_ff <= 1'b0;
                  state_ff <= S_FETCH;
               end else if (status.frm_emit) begin
                  job_ff   <= status.frm_job;
                  count_ff <= status.frm_count;
                  trail_ff <= status.frm_check_lose;
                  state_ff <= S_FETCH;
               end else if (status.frm_check_lose) begin
                  job_ff   <= JOB_LOST;
                  count_ff <= 6'd1;
                  trail_ff <= 1'b0;
                  state_ff <= S_FETCH;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_FETCH: begin
               state_ff <= S_PUT;
            end
            S_PUT: begin
               if (status.slot_free) begin
                  if (at_end) begin
                     if (trail_ff) begin
                        job_ff   <= JOB_LOST;
                        count_ff <= 6'd1;
                        idx_ff   <= '0;
                        trail_ff <= 1'b0;
                        state_ff <= S_FETCH;
                     end else begin
                        state_ff <= S_IDLE;
                     end
                  end else begin
                     idx_ff   <= idx_ff + 5'd1;
                     state_ff <= S_FETCH;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

FILE: sv/slr_datapath.sv
module slr_datapath #(
   parameter int FRAME_DEPTH = 64,
   parameter int MODE_LIMIT  = 7,
   parameter int NAME_LEN    = 11,
   parameter int UNIT_LEN    = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  slr_pkg::dp_cmd_type    cmd,
   output slr_pkg::dp_status_type status,
   input  logic                  func_in,
   input  logic [7:0]            byte_in,
   input  logic [3:0]            max_errors,
   input  logic [7:0]            highest_type,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [3:0]            rsp_kind,
   output logic [2:0]            rsp_mode,
   output logic [4:0]            rsp_index,
   output logic [31:0]           rsp_value,
   output logic                  rsp_last
);
   import slr_pkg::*;

   localparam int AW = $clog2(FRAME_DEPTH);
   localparam int FW = $clog2(FRAME_DEPTH + 1);
   localparam int CW = (FW >= 8) ? FW + 1 : 9;

   logic          func_ff;
   logic [7:0]    byte_ff;
   logic [15:0]   hunt_ff;
   logic          sync_ff, hs_ff, ds_ff, skip_ff, ka_ff;
   logic [8:0]    flags_ff;
   logic [3:0]    mc_ff;
   logic [8:0]    vmc_ff;
   logic [2:0]    cur_ff;
   logic [18:0]   baud_ff;
   logic [FW-1:0] fill_ff;
   logic [3:0]    err_ff;
   logic [7:0]    xr_ff;
   logic [FW-1:0] nz_ff;
   logic          nzstop_ff;
   logic [7:0]    cap_ff [10];
   logic [7:0]    type_ff;
   logic [7:0]    mem [FRAME_DEPTH];
   logic [7:0]    rdata_ff;
   logic [AW-1:0] raddr;

   // dispatch view
   logic       hunt_hit, skip_drop, overflow, complete, wr_en, tick_act;
   logic [7:0] hdr_new;
   logic [3:0] err_tick;

   always_comb begin
      hunt_hit  = (hunt_ff[15:8] == TYPE_HDR) && (hunt_ff[7:0] != 8'd0) &&
                  (hunt_ff[7:0] <= highest_type) &&
                  (byte_ff == (BYTE_FF ^ TYPE_HDR ^ hunt_ff[7:0]));
      skip_drop = skip_ff && (byte_ff == BYTE_FF);
      overflow  = CW'(fill_ff) >= CW'(FRAME_DEPTH);
      hdr_new   = (fill_ff == '0) ? byte_ff : cap_ff[0];
      complete  = (CW'(fill_ff) + CW'(1)) == CW'(frame_len(hdr_new));
      wr_en     = !func_ff && sync_ff && !skip_drop && !overflow;
      tick_act  = sync_ff && hs_ff && ka_ff;
      err_tick  = (!ds_ff && err_ff != 4'hF) ? err_ff + 4'd1 : err_ff;
   end

   // frame evaluation
   logic [7:0]         h, c2;
   logic [2:0]         hcmd;
   logic               ck_ok, f_lose, f_emit, f_check;
   job_type            f_job;
   logic [COUNT_W-1:0] f_count;
   logic [FW-1:0]      lim, nl, ul, dlen;
   logic [31:0]        sp;
   logic [8:0]         f_flags, fmt_flags;
   logic [3:0]         f_mc, f_err;
   logic [8:0]         f_vmc;
   logic [2:0]         f_cur;
   logic [18:0]        f_baud;
   logic               f_hs, f_ka, f_skip, f_ds;
   logic [3:0]         fbit;

   always_comb begin
      h       = cap_ff[0];
      c2      = cap_ff[1];
      hcmd    = h[2:0];
      ck_ok   = (fill_ff == FW'(1)) || (xr_ff == BYTE_FF);
      lim     = fill_ff - FW'(3);
      nl      = (nz_ff < lim) ? nz_ff : lim;
      ul      = (nl > FW'(UNIT_LEN)) ? FW'(UNIT_LEN) : nl;
      dlen    = ((fill_ff - FW'(2)) > FW'(RES_MAX)) ? FW'(RES_MAX) : fill_ff - FW'(2);
      sp      = {cap_ff[4], cap_ff[3], cap_ff[2], cap_ff[1]};
      fbit    = 4'(c2[2:0]) + 4'd3;
      fmt_flags = flags_ff | 9'h100;
      f_lose  = 1'b0;
      f_emit  = 1'b0;
      f_job   = JOB_ACK;
      f_count = 6'd1;
      f_flags = flags_ff;
      f_mc    = mc_ff;
      f_vmc   = vmc_ff;
      f_cur   = cur_ff;
      f_baud  = baud_ff;
      f_hs    = hs_ff;
      f_ka    = ka_ff;
      f_skip  = skip_ff;
      f_ds    = ds_ff;
      f_err   = err_ff;
      if (!ck_ok) begin
         if (!hs_ff) f_lose = 1'b1;
         else if (err_ff != 4'hF) f_err = err_ff + 4'd1;
      end else begin
         unique case (h & HDR_MASK)
            HDR_SYS: begin
               if (hcmd == SYS_SYNC) begin
                  f_skip = 1'b1;
               end else if (hcmd == SYS_ACK) begin
                  if (mc_ff == 4'd0 || (flags_ff & FLAGS_REQUIRED) != FLAGS_REQUIRED) begin
                     f_lose = 1'b1;
                  end else begin
                     f_hs   = 1'b1;
                     f_ka   = 1'b1;
                     f_emit = 1'b1;
                     f_job  = JOB_ACK;
                  end
               end
            end
            HDR_CMD: begin
               if (hcmd == CMD_MODES) begin
                  if (flags_ff[1]) begin
                     f_lose = 1'b1;
                  end else begin
                     f_flags[1] = 1'b1;
                     if (c2 == 8'd0 || c2 > 8'(MODE_LIMIT)) begin
                        f_lose = 1'b1;
                     end else begin
                        f_mc    = c2[3:0] + 4'd1;
                        f_vmc   = (fill_ff > FW'(3)) ? {1'b0, cap_ff[2]} + 9'd1
                                                     : {5'd0, c2[3:0] + 4'd1};
                        f_emit  = 1'b1;
                        f_job   = JOB_MODES;
                        f_count = 6'd2;
                     end
                  end
               end else if (hcmd == CMD_SPEED) begin
                  if (flags_ff[2]) begin
                     f_lose = 1'b1;
                  end else begin
                     f_flags[2] = 1'b1;
                     if (sp < 32'(BAUD_MIN) || sp > BAUD_MAX) begin
                        f_lose = 1'b1;
                     end else begin
                        f_baud = sp[18:0];
                        f_emit = 1'b1;
                        f_job  = JOB_SPEED;
                     end
                  end
               end else begin
                  f_lose = 1'b1;
               end
            end
            HDR_INFO: begin
               if (c2 == INFO_NAME) begin
                  f_flags = flags_ff & ~FLAGS_ALL_INFO;
                  if (cap_ff[2] < CHAR_LO || cap_ff[2] > CHAR_HI ||
                      nl > FW'(NAME_LEN)) begin
                     f_lose = 1'b1;
                  end else begin
                     f_cur      = hcmd;
                     f_flags[3] = 1'b1;
                     f_emit     = 1'b1;
                     f_job      = JOB_NAME;
                     f_count    = COUNT_W'(nl);
                  end
               end else if (c2 >= 8'd1 && c2 <= INFO_UNITS) begin
                  if (cur_ff != hcmd || flags_ff[fbit]) begin
                     f_lose = 1'b1;
                  end else begin
                     f_flags[fbit] = 1'b1;
                     f_emit        = 1'b1;
                     if (c2 != INFO_UNITS) begin
                        f_job   = JOB_RANGE;
                        f_count = 6'd2;
                     end else if (ul == '0) begin
                        f_job = JOB_UNITS_EMPTY;
                     end else begin
                        f_job   = JOB_UNITS;
                        f_count = COUNT_W'(ul);
                     end
                  end
               end else if (c2 == INFO_FMT) begin
                  if (cur_ff != hcmd || flags_ff[8]) begin
                     f_lose = 1'b1;
                  end else begin
                     f_flags[8] = 1'b1;
                     if (cap_ff[2] == 8'd0 || fill_ff < FW'(7) ||
                         (fmt_flags & FLAGS_REQUIRED) != FLAGS_REQUIRED) begin
                        f_lose = 1'b1;
                     end else begin
                        if (cur_ff != 3'd0) f_cur = cur_ff - 3'd1;
                        f_emit  = 1'b1;
                        f_job   = JOB_FORMAT;
                        f_count = 6'd4;
                     end
                  end
               end
            end
            default: begin
               if (!hs_ff) begin
                  f_lose = 1'b1;
               end else begin
                  f_ds    = 1'b1;
                  f_err   = (err_ff != 4'd0) ? err_ff - 4'd1 : err_ff;
                  f_emit  = 1'b1;
                  f_job   = JOB_DATA;
                  f_count = COUNT_W'(dlen);
               end
            end
         endcase
      end
      f_check = !f_lose && f_hs && (f_err > max_errors);
      if (f_job == JOB_DATA && f_emit && f_check && f_count == RES_MAX) begin
         f_count = RES_MAX - 6'd1;
      end
   end

   always_comb begin
      status.slot_free      = !rsp_valid || rsp_ready;
      status.disp_emit      = func_ff ? tick_act : (!sync_ff && hunt_hit);
      status.disp_job       = func_ff ? JOB_NACK : JOB_SYNCED;
      status.disp_lost      = !func_ff && sync_ff && !skip_drop && overflow;
      status.disp_frame     = wr_en && complete;
      status.frm_lose       = f_lose;
      status.frm_emit       = f_emit;
      status.frm_job        = f_job;
      status.frm_count      = f_count;
      status.frm_check_lose = f_check;
   end

   // link state
   always_ff @(posedge clock) begin
      if (reset) begin
         hunt_ff  <= '0;
         sync_ff  <= 1'b0;
         hs_ff    <= 1'b0;
         ds_ff    <= 1'b0;
         flags_ff <= '0;
         mc_ff    <= '0;
         vmc_ff   <= '0;
         cur_ff   <= '0;
         baud_ff  <= BAUD_MIN;
         fill_ff  <= '0;
         err_ff   <= '0;
         skip_ff  <= 1'b0;
         ka_ff    <= 1'b0;
      end else if (cmd.dispatch) begin
         if (func_ff) begin
            if (!sync_ff || !hs_ff) begin
               ka_ff <= 1'b0;
            end else if (ka_ff) begin
               err_ff <= err_tick;
               ds_ff  <= 1'b0;
               if (err_tick > max_errors) ka_ff <= 1'b0;
            end
         end else if (!sync_ff) begin
            if (hunt_hit) begin
               sync_ff  <= 1'b1;
               hs_ff    <= 1'b0;
               ds_ff    <= 1'b0;
               mc_ff    <= 4'd1;
               vmc_ff   <= 9'd1;
               flags_ff <= 9'd1;
               fill_ff  <= '0;
               err_ff   <= '0;
               skip_ff  <= 1'b0;
               ka_ff    <= 1'b0;
               hunt_ff  <= '0;
            end else begin
               hunt_ff <= {hunt_ff[7:0], byte_ff};
            end
         end else begin
            skip_ff <= 1'b0;
            if (wr_en) fill_ff <= fill_ff + FW'(1);
         end
      end else if (cmd.apply_frame) begin
         flags_ff <= f_flags;
         mc_ff    <= f_mc;
         vmc_ff   <= f_vmc;
         cur_ff   <= f_cur;
         baud_ff  <= f_baud;
         hs_ff    <= f_hs;
         ka_ff    <= f_ka;
         skip_ff  <= f_skip;
         ds_ff    <= f_ds;
         err_ff   <= f_err;
         fill_ff  <= '0;
      end else if (cmd.put && cmd.job == JOB_LOST) begin
         sync_ff <= 1'b0;
         baud_ff <= BAUD_MIN;
         hunt_ff <= '0;
         skip_ff <= 1'b0;
         ka_ff   <= 1'b0;
         fill_ff <= '0;
      end
   end

   // beat capture, frame bytes and running checks
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= func_in;
         byte_ff <= byte_in;
      end
      if (cmd.dispatch && !func_ff && !sync_ff && hunt_hit) begin
         type_ff <= hunt_ff[7:0];
      end
      if (cmd.dispatch && wr_en) begin
         mem[fill_ff[AW-1:0]] <= byte_ff;
         if (fill_ff < FW'(10)) cap_ff[fill_ff[3:0]] <= byte_ff;
         xr_ff <= (fill_ff == '0) ? byte_ff : (xr_ff ^ byte_ff);
         if (fill_ff == FW'(2)) begin
            nz_ff     <= (byte_ff != 8'd0) ? FW'(1) : '0;
            nzstop_ff <= (byte_ff == 8'd0);
         end else if (fill_ff > FW'(2) && !nzstop_ff) begin
            if (byte_ff == 8'd0) nzstop_ff <= 1'b1;
            else nz_ff <= nz_ff + FW'(1);
         end
      end
   end

   assign raddr = (cmd.job == JOB_DATA) ? AW'(cmd.idx) + AW'(1) : AW'(cmd.idx) + AW'(2);

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   // result assembly
   logic [3:0]  o_kind;
   logic [2:0]  o_mode;
   logic [31:0] o_value;

   always_comb begin
      o_mode  = 3'd0;
      o_value = 32'd0;
      o_kind  = KIND_LOST;
      unique case (cmd.job)
         JOB_SYNCED: begin
            o_kind  = KIND_SYNCED;
            o_value = {24'd0, type_ff};
         end
         JOB_MODES: begin
            o_kind  = KIND_MODES;
            o_value = (cmd.idx == 5'd0) ? {28'd0, mc_ff} : {23'd0, vmc_ff};
         end
         JOB_SPEED: begin
            o_kind  = KIND_SPEED;
            o_value = {13'd0, baud_ff};
         end
         JOB_NAME: begin
            o_kind  = KIND_NAME;
            o_mode  = cap_ff[0][2:0];
            o_value = {24'd0, rdata_ff};
         end
         JOB_RANGE: begin
            o_kind  = KIND_NAME + cap_ff[1][3:0];
            o_mode  = cap_ff[0][2:0];
            o_value = (cmd.idx == 5'd0) ? {cap_ff[5], cap_ff[4], cap_ff[3], cap_ff[2]}
                                        : {cap_ff[9], cap_ff[8], cap_ff[7], cap_ff[6]};
         end
         JOB_UNITS: begin
            o_kind  = KIND_UNITS;
            o_mode  = cap_ff[0][2:0];
            o_value = {24'd0, rdata_ff};
         end
         JOB_UNITS_EMPTY: begin
            o_kind = KIND_UNITS;
            o_mode = cap_ff[0][2:0];
         end
         JOB_FORMAT: begin
            o_kind = KIND_FORMAT;
            o_mode = cap_ff[0][2:0];
            case (cmd.idx[1:0])
               2'd0: o_value = {24'd0, cap_ff[2]};
               2'd1: o_value = {24'd0, cap_ff[3]};
               2'd2: o_value = (cap_ff[0][2:0] != 3'd0) ? {24'd0, cap_ff[4]} : 32'd4;
               default: o_value = (cap_ff[0][2:0] != 3'd0) ? {24'd0, cap_ff[5]} : 32'd0;
            endcase
         end
         JOB_ACK: begin
            o_kind  = KIND_ACK;
            o_value = {13'd0, baud_ff};
         end
         JOB_DATA: begin
            o_kind  = KIND_DATA;
            o_mode  = cap_ff[0][2:0];
            o_value = {24'd0, rdata_ff};
         end
         JOB_NACK: begin
            o_kind = KIND_NACK;
         end
         default: begin
            o_kind  = KIND_LOST;
            o_value = {13'd0, BAUD_MIN};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.put) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put) begin
         rsp_kind  <= o_kind;
         rsp_mode  <= o_mode;
         rsp_index <= cmd.idx;
         rsp_value <= o_value;
         rsp_last  <= cmd.last;
      end
   end
endmodule

FILE: sv/slr_checker.sv
module slr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_kind,
   input logic [31:0] rsp_value,
   input logic        rsp_last,
   input logic        csr_pready
);
   import slr_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous beat still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kind) && $stable(rsp_value)))
      else $error("stalled result beat changed");

   a_lost_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_LOST) |-> (rsp_last && rsp_value == 32'd2400))
      else $error("sync lost beat not final or wrong baud");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr pready dropped");
endmodule

bind sensor_uart_link_receiver_top slr_checker u_slr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_kind   (rsp_chan.kind),
   .rsp_value  (rsp_chan.value),
   .rsp_last   (rsp_chan.last),
   .csr_pready (csr_pready)
);
